FILE: sv/slrc_pkg.sv
// Shared types and constants for the lock motor ramp controller.
// No dependencies; imported by slrc_core and solenoid_lock_ramp_controller.
`default_nettype none

package slrc_pkg;

  // Item opcodes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_LOCK   = 2'd1;
  localparam logic [1:0] OP_UNLOCK = 2'd2;

  // Register indexes (word address on the configuration port)
  localparam logic [2:0] REG_ENABLE      = 3'd0;
  localparam logic [2:0] REG_PWM_PERIOD  = 3'd1;
  localparam logic [2:0] REG_DUTY_STEP   = 3'd2;
  localparam logic [2:0] REG_CLOSE_SETTLE = 3'd3;
  localparam logic [2:0] REG_OPEN_SETTLE = 3'd4;

  // Register reset values
  localparam logic        RST_ENABLE       = 1'b1;
  localparam logic [15:0] RST_PWM_PERIOD   = 16'd1000;
  localparam logic [7:0]  RST_DUTY_STEP    = 8'd3;
  localparam logic [15:0] RST_CLOSE_SETTLE = 16'd75;
  localparam logic [15:0] RST_OPEN_SETTLE  = 16'd50;

  localparam logic [15:0] AGE_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_INITIAL = 3'd0,
    ST_OPEN    = 3'd1,
    ST_CLOSING = 3'd2,
    ST_CLOSED  = 3'd3,
    ST_OPENING = 3'd4
  } lock_state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       feedback_closed;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  lock_state;
    logic [15:0] close_drive;
    logic [15:0] open_drive;
  } out_item_t;

  typedef struct packed {
    logic        enable;
    logic [15:0] pwm_period;
    logic [7:0]  duty_step;
    logic [15:0] close_settle_ms;
    logic [15:0] open_settle_ms;
  } cfg_t;

endpackage

`default_nettype wire

FILE: sv/slrc_core.sv
// Motion state, duty ramp and feedback age tracking for the lock controller.
// Depends on slrc_pkg; updates state once per fired transaction.
`default_nettype none

module slrc_core import slrc_pkg::*; #(
  parameter int DUTY_WIDTH = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      fire,
  input  wire in_item_t  item,
  input  wire cfg_t      cfg,
  output out_item_t      result
);

  localparam int LW = (DUTY_WIDTH > 16) ? DUTY_WIDTH : 16;
  localparam logic [LW-1:0] WMAX = LW'({DUTY_WIDTH{1'b1}});

  lock_state_t           state_r, state_nxt;
  logic [DUTY_WIDTH-1:0] duty_r, duty_nxt;
  logic                  closed_seen_r, closed_seen_nxt;
  logic                  opened_seen_r, opened_seen_nxt;
  logic [15:0]           closed_age_r, closed_age_nxt;
  logic [15:0]           opened_age_r, opened_age_nxt;

  logic [LW-1:0]         period_w;
  logic [DUTY_WIDTH-1:0] lim;
  logic [DUTY_WIDTH:0]   ramp;
  logic [DUTY_WIDTH-1:0] duty_cap;
  logic                  moving;

  // Ramp ceiling: pwm_period, clipped to what the duty register holds
  always_comb begin
    period_w = LW'(cfg.pwm_period);
    lim      = (period_w > WMAX) ? DUTY_WIDTH'(WMAX) : DUTY_WIDTH'(period_w);
    ramp     = {1'b0, duty_r} + (DUTY_WIDTH+1)'(cfg.duty_step);
    moving   = (state_r == ST_CLOSING) || (state_r == ST_OPENING);
  end

  // Next state
  always_comb begin
    state_nxt       = state_r;
    duty_nxt        = duty_r;
    closed_seen_nxt = closed_seen_r;
    opened_seen_nxt = opened_seen_r;
    closed_age_nxt  = closed_age_r;
    opened_age_nxt  = opened_age_r;
    case (item.opcode)
      OP_TICK: begin
        if (cfg.enable) begin
          if (closed_seen_r) begin
            closed_age_nxt = (closed_age_r == AGE_MAX) ? AGE_MAX : closed_age_r + 16'd1;
          end
          if (opened_seen_r) begin
            opened_age_nxt = (opened_age_r == AGE_MAX) ? AGE_MAX : opened_age_r + 16'd1;
          end
          if (!moving) begin
            duty_nxt = '0;
          end else begin
            duty_nxt = (ramp > {1'b0, lim}) ? lim : ramp[DUTY_WIDTH-1:0];
            if (item.feedback_closed) begin
              opened_seen_nxt = 1'b0;
              if (!closed_seen_r) begin
                closed_seen_nxt = 1'b1;
                closed_age_nxt  = '0;
              end
            end else begin
              closed_seen_nxt = 1'b0;
              if (!opened_seen_r) begin
                opened_seen_nxt = 1'b1;
                opened_age_nxt  = '0;
              end
            end
            // Finish once the level has held for the settle time
            if (state_r == ST_CLOSING && item.feedback_closed &&
                closed_age_nxt >= cfg.close_settle_ms) begin
              state_nxt = ST_CLOSED;
              duty_nxt  = '0;
            end else if (state_r == ST_OPENING && !item.feedback_closed &&
                         opened_age_nxt >= cfg.open_settle_ms) begin
              state_nxt = ST_OPEN;
              duty_nxt  = '0;
            end
          end
        end
      end
      OP_LOCK: begin
        if (state_r != ST_CLOSING && state_r != ST_CLOSED) begin
          state_nxt = ST_CLOSING;
          duty_nxt  = '0;
        end
      end
      OP_UNLOCK: begin
        if (state_r != ST_OPENING && state_r != ST_OPEN) begin
          state_nxt = ST_OPENING;
          duty_nxt  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Outputs: drive follows the updated state, capped at the ceiling
  always_comb begin
    duty_cap           = (duty_nxt > lim) ? lim : duty_nxt;
    result.lock_state  = state_nxt;
    result.close_drive = '0;
    result.open_drive  = '0;
    if (cfg.enable) begin
      if (state_nxt == ST_CLOSING) begin
        result.close_drive = 16'(duty_cap);
      end else if (state_nxt == ST_OPENING) begin
        result.open_drive = 16'(duty_cap);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_INITIAL;
      duty_r        <= '0;
      closed_seen_r <= 1'b0;
      opened_seen_r <= 1'b0;
      closed_age_r  <= '0;
      opened_age_r  <= '0;
    end else if (fire) begin
      state_r       <= state_nxt;
      duty_r        <= duty_nxt;
      closed_seen_r <= closed_seen_nxt;
      opened_seen_r <= opened_seen_nxt;
      closed_age_r  <= closed_age_nxt;
      opened_age_r  <= opened_age_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/solenoid_lock_ramp_controller.sv
// Top level of the lock motor ramp controller: channels, registers, pipeline.
// Depends on slrc_pkg and slrc_core.
`default_nettype none

// Each transaction on the input channel is a 1 ms tick carrying the feedback
// switch level, or a lock or unlock request; each yields exactly one result
// transaction with the lock state and the duty for the close and open motor
// inputs. The block takes one transaction per clock cycle while in_stall is
// low; an accepted transaction waits in the input register, then the single
// state update writes its result into the output register. Throughput is set
// by that update of the motion state, duty and feedback ages. A stalled output
// holds both stages, and in_stall rises only while the input register is full
// and cannot move forward. Registers sit at byte addresses 0 (enable),
// 4 (pwm_period), 8 (duty_step), 12 (close_settle_ms) and 16 (open_settle_ms);
// write them only while no transaction is in flight.

module solenoid_lock_ramp_controller import slrc_pkg::*; #(
  parameter int DUTY_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_item,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_item,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t      cfg_r;
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t core_result;
  logic      advance;
  logic      fire;
  logic      cfg_wr;
  logic [2:0] reg_idx;

  // Register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable          <= RST_ENABLE;
      cfg_r.pwm_period      <= RST_PWM_PERIOD;
      cfg_r.duty_step       <= RST_DUTY_STEP;
      cfg_r.close_settle_ms <= RST_CLOSE_SETTLE;
      cfg_r.open_settle_ms  <= RST_OPEN_SETTLE;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ENABLE:       cfg_r.enable          <= pwdata[0];
        REG_PWM_PERIOD:   cfg_r.pwm_period      <= pwdata[15:0];
        REG_DUTY_STEP:    cfg_r.duty_step       <= pwdata[7:0];
        REG_CLOSE_SETTLE: cfg_r.close_settle_ms <= pwdata[15:0];
        REG_OPEN_SETTLE:  cfg_r.open_settle_ms  <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Read back; unmapped addresses return zero
  always_comb begin
    case (reg_idx)
      REG_ENABLE:       prdata = {31'd0, cfg_r.enable};
      REG_PWM_PERIOD:   prdata = {16'd0, cfg_r.pwm_period};
      REG_DUTY_STEP:    prdata = {24'd0, cfg_r.duty_step};
      REG_CLOSE_SETTLE: prdata = {16'd0, cfg_r.close_settle_ms};
      REG_OPEN_SETTLE:  prdata = {16'd0, cfg_r.open_settle_ms};
      default:          prdata = '0;
    endcase
  end

  // Pipeline control: advance when the output register is free or drains
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  // Input register: hold while stalled, refill whenever it moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item_r <= in_item;
    end
  end

  slrc_core #(
    .DUTY_WIDTH (DUTY_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_item_r),
    .cfg    (cfg_r),
    .result (core_result)
  );

  // Output register: load on fire, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= core_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking bench for solenoid_lock_ramp_controller: directed items and random
// motion episodes, with one long receiver hold-off that backs up the input.
// Depends on slrc_pkg and the RTL top level; needs no other file.
`timescale 1ns / 100ps

module tb;
  import slrc_pkg::*;

  // Opcode 3 is not a defined operation; the block must ignore it.
  localparam logic [1:0] OP_UNKNOWN  = 2'd3;
  localparam int         CYCLE_LIMIT = 2_000_000;
  localparam int         HOLD_CYCLES = 300;

  // Tracks the controller state on the side and holds one expected result per
  // accepted transaction, oldest first.
  class lock_scoreboard;
    cfg_t        regs;
    lock_state_t motion;
    int unsigned duty;
    bit          closed_seen;
    bit          opened_seen;
    logic [15:0] closed_age;
    logic [15:0] opened_age;
    out_item_t   expected_q[$];
    int          mismatches;

    function new();
      regs.enable          = RST_ENABLE;
      regs.pwm_period      = RST_PWM_PERIOD;
      regs.duty_step       = RST_DUTY_STEP;
      regs.close_settle_ms = RST_CLOSE_SETTLE;
      regs.open_settle_ms  = RST_OPEN_SETTLE;
      motion      = ST_INITIAL;
      duty        = 0;
      closed_seen = 1'b0;
      opened_seen = 1'b0;
      closed_age  = 16'd0;
      opened_age  = 16'd0;
      mismatches  = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH: %s", msg);
    endfunction

    // Store a register write; return the value a read should give back.
    function logic [31:0] set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_ENABLE: begin
          regs.enable = value[0];
          return {31'd0, value[0]};
        end
        REG_PWM_PERIOD: begin
          regs.pwm_period = value[15:0];
          return {16'd0, value[15:0]};
        end
        REG_DUTY_STEP: begin
          regs.duty_step = value[7:0];
          return {24'd0, value[7:0]};
        end
        REG_CLOSE_SETTLE: begin
          regs.close_settle_ms = value[15:0];
          return {16'd0, value[15:0]};
        end
        REG_OPEN_SETTLE: begin
          regs.open_settle_ms = value[15:0];
          return {16'd0, value[15:0]};
        end
        default: return 32'd0;
      endcase
    endfunction

    // Advance the lock state for one accepted transaction and queue its result.
    function void note_input(in_item_t it);
      out_item_t   res;
      int unsigned lim;
      int unsigned sum;
      int unsigned shown;
      bit          moving;
      bit          fb;
      lim = 32'(regs.pwm_period);
      fb  = it.feedback_closed;
      case (it.opcode)
        OP_TICK: begin
          if (regs.enable) begin
            moving = (motion == ST_CLOSING) || (motion == ST_OPENING);
            // ages run on every enabled tick once seen, saturating
            if (closed_seen && closed_age != AGE_MAX) closed_age = closed_age + 16'd1;
            if (opened_seen && opened_age != AGE_MAX) opened_age = opened_age + 16'd1;
            if (!moving) begin
              duty = 0;
            end else begin
              sum  = duty + 32'(regs.duty_step);
              duty = (sum > lim) ? lim : sum;
              if (fb) begin
                opened_seen = 1'b0;
                if (!closed_seen) begin
                  closed_seen = 1'b1;
                  closed_age  = 16'd0;
                end
              end else begin
                closed_seen = 1'b0;
                if (!opened_seen) begin
                  opened_seen = 1'b1;
                  opened_age  = 16'd0;
                end
              end
              if (motion == ST_CLOSING && fb && closed_age >= regs.close_settle_ms) begin
                motion = ST_CLOSED;
                duty   = 0;
              end else if (motion == ST_OPENING && !fb &&
                           opened_age >= regs.open_settle_ms) begin
                motion = ST_OPEN;
                duty   = 0;
              end
            end
          end
        end
        OP_LOCK: begin
          if (motion != ST_CLOSING && motion != ST_CLOSED) begin
            motion = ST_CLOSING;
            duty   = 0;
          end
        end
        OP_UNLOCK: begin
          if (motion != ST_OPENING && motion != ST_OPEN) begin
            motion = ST_OPENING;
            duty   = 0;
          end
        end
        default: ;
      endcase
      shown           = (duty > lim) ? lim : duty;
      res.lock_state  = motion;
      res.close_drive = 16'd0;
      res.open_drive  = 16'd0;
      if (regs.enable) begin
        if (motion == ST_CLOSING) res.close_drive = 16'(shown);
        else if (motion == ST_OPENING) res.open_drive = 16'(shown);
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("result %h with nothing expected", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.lock_state !== want.lock_state)
        flag($sformatf("lock_state expected %0d, got %0d", want.lock_state, got.lock_state));
      if (got.close_drive !== want.close_drive)
        flag($sformatf("close_drive expected %0d, got %0d", want.close_drive,
                       got.close_drive));
      if (got.open_drive !== want.open_drive)
        flag($sformatf("open_drive expected %0d, got %0d", want.open_drive, got.open_drive));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lock_scoreboard sb = new();

  bit gaps_on   = 1'b1;
  int burst_left = 0;
  bit hold_req  = 1'b0;
  int cls_set   = 75;
  int opn_set   = 50;

  solenoid_lock_ramp_controller i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Sample both channels at the rising edge, before the block updates them.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_item);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  // Offer one transaction and hold it until accepted; the sender works in
  // bursts with random gaps between them.
  task automatic send_op(input logic [1:0] op, input logic fb);
    if (gaps_on && burst_left == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_item  = in_item_t'(3'($urandom_range(0, 7)));
      repeat ($urandom_range(0, 7)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid               = 1'b1;
    in_item.opcode          = op;
    in_item.feedback_closed = fb;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every expected result is back.
  task automatic wait_quiet();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Setup and access cycle for the write, then read the register back.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] stored;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    stored  = sb.set_reg(idx, value);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata !== stored)
      sb.flag($sformatf("register %0d read expected %h, got %h", idx, stored, prdata));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Receiver stall pattern: spans of no stall, sparse, periodic and heavy
  // stalling; a hold-off request parks the receiver until its hold count runs out.
  initial begin : rx_pattern
    int mode;
    int span;
    int period;
    int hold_n;
    out_stall = 1'b0;
    hold_n    = 0;
    forever begin
      mode   = $urandom_range(0, 3);
      span   = $urandom_range(20, 200);
      period = $urandom_range(2, 5);
      for (int k = 0; k < span; k++) begin
        @(negedge clk);
        if (hold_req) begin
          out_stall = 1'b1;
          hold_n++;
          if (hold_n == HOLD_CYCLES) begin
            hold_req = 1'b0;
            hold_n   = 0;
          end
        end else begin
          case (mode)
            0:       out_stall = 1'b0;
            1:       out_stall = ($urandom_range(0, 9) < 3);
            2:       out_stall = (k % period == 0);
            default: out_stall = ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("solenoid_lock_ramp_controller regression: fail");
    $finish;
  end

  initial begin : stimulus
    int         count;
    int         travel;
    int         span;
    int         settle_val;
    bit         lvl;
    bit         fb;
    logic [1:0] op;
    logic [15:0] v16;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset settings, requests from the initial, closing and opening
    // states, ignored requests, and the undefined opcode.
    send_op(OP_TICK, 1'b0);
    send_op(OP_UNKNOWN, 1'b1);
    send_op(OP_LOCK, 1'b1);
    send_op(OP_LOCK, 1'b0);
    send_op(OP_TICK, 1'b0);
    send_op(OP_TICK, 1'b1);
    send_op(OP_UNLOCK, 1'b0);
    send_op(OP_UNLOCK, 1'b1);
    send_op(OP_TICK, 1'b0);
    wait_quiet();

    // Zero settle times finish on the first matching tick; a zero period
    // pins the duty at zero.
    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_PWM_PERIOD, 32'd0);
    write_reg(REG_DUTY_STEP, 32'd255);
    write_reg(REG_CLOSE_SETTLE, 32'd0);
    write_reg(REG_OPEN_SETTLE, 32'd0);
    cls_set = 0;
    opn_set = 0;
    send_op(OP_LOCK, 1'b0);
    send_op(OP_TICK, 1'b0);
    send_op(OP_TICK, 1'b1);
    send_op(OP_LOCK, 1'b1);
    send_op(OP_UNLOCK, 1'b0);
    send_op(OP_TICK, 1'b0);
    send_op(OP_UNLOCK, 1'b0);
    wait_quiet();

    // Disabled: ticks change nothing and drives read zero, requests still move.
    write_reg(REG_ENABLE, 32'd0);
    write_reg(REG_PWM_PERIOD, 32'd65535);
    send_op(OP_TICK, 1'b1);
    send_op(OP_LOCK, 1'b0);
    send_op(OP_TICK, 1'b1);
    send_op(OP_UNLOCK, 1'b1);
    wait_quiet();

    // Ramp into the period ceiling while opening.
    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_PWM_PERIOD, 32'd20);
    write_reg(REG_DUTY_STEP, 32'd7);
    write_reg(REG_OPEN_SETTLE, 32'd65535);
    opn_set = 65535;
    repeat (4) send_op(OP_TICK, 1'b1);

    // Random phases: new settings each time, mostly well-formed motion
    // episodes with some noise. Phase 2 also holds the receiver off.
    for (int ph = 0; ph < 10; ph++) begin
      wait_quiet();
      if ($urandom_range(0, 1)) write_reg(REG_ENABLE,
                                          {31'($urandom), 1'($urandom_range(0, 4) != 0)});
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 5))
          0:       v16 = 16'd0;
          1:       v16 = 16'd1;
          2:       v16 = 16'hFFFF;
          default: v16 = 16'($urandom_range(2, 80));
        endcase
        write_reg(REG_PWM_PERIOD, {16'($urandom), v16});
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 4))
          0:       v16 = 16'd0;
          1:       v16 = 16'd255;
          default: v16 = 16'($urandom_range(1, 40));
        endcase
        write_reg(REG_DUTY_STEP, {24'($urandom), v16[7:0]});
      end
      for (int r = 0; r < 2; r++) begin
        if ($urandom_range(0, 1)) begin
          case ($urandom_range(0, 6))
            0:       v16 = 16'd0;
            1:       v16 = 16'hFFFF;
            default: v16 = 16'($urandom_range(0, 20));
          endcase
          if (r == 0) begin
            write_reg(REG_CLOSE_SETTLE, {16'($urandom), v16});
            cls_set = int'(v16);
          end else begin
            write_reg(REG_OPEN_SETTLE, {16'($urandom), v16});
            opn_set = int'(v16);
          end
        end
      end
      gaps_on = (ph != 2);
      if (ph == 2) hold_req = 1'b1;

      count = 0;
      while (count < 175) begin
        if ($urandom_range(0, 9) < 8) begin
          lvl = 1'($urandom_range(0, 1));
          send_op(lvl ? OP_LOCK : OP_UNLOCK, 1'($urandom_range(0, 1)));
          count++;
          // switch travels for a while, then sits at the target with bounces
          travel     = $urandom_range(0, 6);
          settle_val = lvl ? cls_set : opn_set;
          if (settle_val > 40) settle_val = 40;
          span = travel + settle_val + $urandom_range(1, 4);
          for (int k = 0; k < span; k++) begin
            fb = (k < travel) ? !lvl : lvl;
            if ($urandom_range(0, 11) == 0) fb = !fb;
            send_op(OP_TICK, fb);
            count++;
          end
        end else begin
          repeat ($urandom_range(1, 6)) begin
            op = 2'($urandom_range(0, 3));
            send_op(op, 1'($urandom_range(0, 1)));
            if (op != OP_UNKNOWN) count++;
          end
        end
      end
    end

    wait_quiet();
    repeat (10) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.flag($sformatf("%0d results never arrived", sb.expected_q.size()));
    if (sb.mismatches == 0) begin
      $display("solenoid_lock_ramp_controller regression: pass");
    end else begin
      $display("solenoid_lock_ramp_controller regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/slrc_pkg.sv
sv/slrc_core.sv
sv/solenoid_lock_ramp_controller.sv
dv/tb.sv
